// File: hw/rtl/fpf_pkg.sv
`default_nettype none

package fpf_pkg;

    // Default widths of the sample path and the coefficient fraction
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Configuration register map
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CUTOFF_KNOB = 2'd0,
        REG_RESONANCE   = 2'd1
    } t_cfg_reg;

    // Register values after reset, Q0.16 one half
    localparam logic [COEF_FRAC_BITS_DEF-1:0] KNOB_RESET_DEF = 16'd32768;
    localparam logic [COEF_FRAC_BITS_DEF-1:0] RES_RESET_DEF  = 16'd32768;

endpackage

`default_nettype wire

// File: hw/rtl/fpf_if.sv
`default_nettype none

// Sample input channel
interface fpf_in_if #(
    parameter int SAMPLE_BITS = fpf_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] audio_in;
    logic signed [SAMPLE_BITS-1:0] cutoff_cv;

    modport source (output valid, output audio_in, output cutoff_cv, input ready);
    modport sink   (input valid, input audio_in, input cutoff_cv, output ready);
endinterface

// Filter result channel
interface fpf_out_if #(
    parameter int SAMPLE_BITS = fpf_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] lowpass_out;
    logic signed [SAMPLE_BITS-1:0] bandpass_out;
    logic signed [SAMPLE_BITS-1:0] highpass_out;

    modport source (output valid, output lowpass_out, output bandpass_out,
                    output highpass_out, input ready);
    modport sink   (input valid, input lowpass_out, input bandpass_out,
                    input highpass_out, output ready);
endinterface

// Register write channel
interface fpf_cfg_if #(
    parameter int COEF_FRAC_BITS = fpf_pkg::COEF_FRAC_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic [fpf_pkg::CFG_INDEX_W-1:0]  index;
    logic [COEF_FRAC_BITS-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fpf_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle
module fpf_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_den, n_den;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // Bring down the next numerator bit and try one subtraction
    assign trial = {r_rem, r_num[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_num  = r_num;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_num  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            // Quotient bits shift in from the bottom as numerator bits leave
            if (!diff[DEN_W]) begin
                n_rem = diff[DEN_W-1:0];
                n_num = {r_num[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DEN_W-1:0];
                n_num = {r_num[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_num <= n_num;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

// File: hw/rtl/fpf_mul.sv
`default_nettype none

// Shared signed-by-unsigned multiplier with registered product
module fpf_mul #(
    parameter int A_W = 33,
    parameter int B_W = 24
) (
    input  wire logic                    i_clk,
    input  wire logic signed [A_W-1:0]   i_a,
    input  wire logic        [B_W-1:0]   i_b,
    output logic signed [A_W+B_W:0]      o_p
);

    logic signed [A_W+B_W:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * $signed({1'b0, i_b});
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// File: hw/rtl/four_pole_resonant_filter.sv
`default_nettype none

// Four-pole resonant low-pass filter with band-pass and high-pass taps. Each
// transfer on i_in carries one sample and one cutoff CV (signed, SAMPLE_BITS-5
// fraction bits); each transfer on o_out carries lowpass, bandpass and
// highpass, saturated to SAMPLE_BITS. The input is not ready from a transfer
// until its result is loaded into the output register: the feedback gain
// needs a resonance / (1 - cutoff) quotient from a one-bit-per-cycle
// divider, after which five multiply and accumulate steps, each a multiply
// state then an accumulate state, share one multiplier. A finished result
// waits in an output register, so the next sample is taken while it is
// still held. Registers: index 0 cutoff knob, index 1 resonance, both
// unsigned Q0.COEF_FRAC_BITS; other indexes are ignored, and writes are
// accepted at any time but must only be made while no sample is in flight.
module four_pole_resonant_filter #(
    parameter int SAMPLE_BITS    = fpf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = fpf_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fpf_in_if.sink     i_in,
    fpf_cfg_if.sink    i_cfg,
    fpf_out_if.source  o_out
);

    localparam int SB    = SAMPLE_BITS;
    localparam int CF    = COEF_FRAC_BITS;
    localparam int VF    = SB - 5;
    localparam int SHIFT = VF - CF;
    localparam int RSH   = (SHIFT >= 0) ? SHIFT : 0;
    localparam int LSH   = (SHIFT < 0) ? -SHIFT : 0;
    localparam int CW    = SB + CF + 2;   // cutoff sum
    localparam int AW    = SB + 9;        // multiplier signed operand
    localparam int BW    = CF + 8;        // multiplier unsigned operand, feedback gain
    localparam int PW    = AW + BW + 1;   // product
    localparam int EW    = SB + 20;       // accumulate and saturate
    localparam int NW    = 2 * CF;        // divider numerator

    localparam int C_LO_I = ((1 << CF) + 50) / 100;
    localparam int C_HI_I = ((1 << CF) * 99 + 50) / 100;
    localparam logic signed [CW-1:0] C_LO_W = CW'(C_LO_I);
    localparam logic signed [CW-1:0] C_HI_W = CW'(C_HI_I);
    localparam logic [CF-1:0] C_LO_C = CF'(C_LO_I);
    localparam logic [CF-1:0] C_HI_C = CF'(C_HI_I);

    localparam logic signed [EW-1:0] S_MAX = {{(EW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [EW-1:0] S_MIN = ~S_MAX;
    localparam logic signed [EW-1:0] B_MAX = {{(EW-SB-7){1'b0}}, {(SB+7){1'b1}}};
    localparam logic signed [EW-1:0] B_MIN = ~B_MAX;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_COEF = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        OP_TERM = 3'd0,
        OP_S1   = 3'd1,
        OP_S2   = 3'd2,
        OP_S3   = 3'd3,
        OP_S4   = 3'd4
    } t_op;

    function automatic logic signed [EW-1:0] ext_s(input logic signed [SB-1:0] v);
        return {{(EW-SB){v[SB-1]}}, v};
    endfunction

    function automatic logic signed [SB-1:0] sat_s(input logic signed [EW-1:0] v);
        logic signed [SB-1:0] r;
        if (v > S_MAX) begin
            r = S_MAX[SB-1:0];
        end else if (v < S_MIN) begin
            r = S_MIN[SB-1:0];
        end else begin
            r = v[SB-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [AW-1:0] sat_b(input logic signed [EW-1:0] v);
        logic signed [AW-1:0] r;
        if (v > B_MAX) begin
            r = B_MAX[AW-1:0];
        end else if (v < B_MIN) begin
            r = B_MIN[AW-1:0];
        end else begin
            r = v[AW-1:0];
        end
        return r;
    endfunction

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [CF-1:0]         r_knob, r_res;
    logic signed [SB-1:0]  r_x, n_x;
    logic signed [SB-1:0]  r_cv, n_cv;
    logic [CF-1:0]         r_c, n_c;
    logic [BW-1:0]         r_fb, n_fb;
    logic signed [AW-1:0]  r_a, n_a;
    logic signed [SB-1:0]  r_s1, n_s1, r_s2, n_s2, r_s3, n_s3, r_s4, n_s4;
    logic                  r_out_valid, n_out_valid;
    logic signed [SB-1:0]  r_lp, n_lp, r_bp, n_bp, r_hp, n_hp;

    logic signed [CW-1:0]  cv_ext, cvc, knob_ext, c_sum;
    logic [CF-1:0]         c_new;
    logic [CF:0]           den_full;
    logic                  div_start, div_done;
    logic [NW-1:0]         div_quot;
    logic [BW-1:0]         mul_b;
    logic signed [PW-1:0]  mul_p;
    logic signed [EW-1:0]  sh_ext;
    logic signed [SB-1:0]  acc_base, acc_next;
    logic signed [SB-1:0]  acc_sat;
    logic signed [EW-1:0]  next_diff;
    logic signed [AW-1:0]  bracket;
    logic                  load_out;

    // Register writes; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knob <= CF'(fpf_pkg::KNOB_RESET_DEF);
            r_res  <= CF'(fpf_pkg::RES_RESET_DEF);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                fpf_pkg::REG_CUTOFF_KNOB: r_knob <= i_cfg.data;
                fpf_pkg::REG_RESONANCE:   r_res  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Cutoff: knob plus scaled CV, clamped
    assign cv_ext   = {{(CW-SB){r_cv[SB-1]}}, r_cv};
    assign cvc      = (cv_ext >>> RSH) <<< LSH;
    assign knob_ext = {{(CW-CF){1'b0}}, r_knob};
    assign c_sum    = cvc + knob_ext;

    always_comb begin
        if (c_sum > C_HI_W) begin
            c_new = C_HI_C;
        end else if (c_sum < C_LO_W) begin
            c_new = C_LO_C;
        end else begin
            c_new = c_sum[CF-1:0];
        end
    end

    // Feedback gain quotient: resonance * 2^C / (2^C - cutoff)
    assign den_full  = {1'b1, {CF{1'b0}}} - {1'b0, c_new};
    assign div_start = (r_state == ST_COEF);

    fpf_div #(
        .NUM_W (NW),
        .DEN_W (CF)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_res, {CF{1'b0}}}),
        .i_den   (den_full[CF-1:0]),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Shared multiplier: gain for the feedback term, cutoff for the stages
    assign mul_b = (r_op == OP_TERM) ? r_fb : {8'b0, r_c};

    fpf_mul #(
        .A_W (AW),
        .B_W (BW)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (r_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign sh_ext = {{(EW-(PW-CF)){mul_p[PW-1]}}, mul_p[PW-1:CF]};

    // Pick the stage being updated and the stage that follows it
    always_comb begin
        unique case (r_op)
            OP_TERM: begin acc_base = r_s1; acc_next = r_s2; end
            OP_S1:   begin acc_base = r_s1; acc_next = r_s2; end
            OP_S2:   begin acc_base = r_s2; acc_next = r_s3; end
            OP_S3:   begin acc_base = r_s3; acc_next = r_s4; end
            OP_S4:   begin acc_base = r_s4; acc_next = r_s4; end
            default: begin acc_base = r_s1; acc_next = r_s2; end
        endcase
    end

    assign acc_sat   = sat_s(ext_s(acc_base) + sh_ext);
    assign next_diff = ext_s(acc_sat) - ext_s(acc_next);
    assign bracket   = sat_b(ext_s(r_x) - ext_s(r_s1) + sh_ext);

    assign load_out = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_x         = r_x;
        n_cv        = r_cv;
        n_c         = r_c;
        n_fb        = r_fb;
        n_a         = r_a;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_s3        = r_s3;
        n_s4        = r_s4;
        n_out_valid = r_out_valid;
        n_lp        = r_lp;
        n_bp        = r_bp;
        n_hp        = r_hp;

        // Drop the held result once it is transferred
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_x     = i_in.audio_in;
                    n_cv    = i_in.cutoff_cv;
                    n_state = ST_COEF;
                end
            end
            ST_COEF: begin
                n_c     = c_new;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_fb    = {8'b0, r_res} + div_quot[BW-1:0];
                    n_a     = AW'(ext_s(r_s1) - ext_s(r_s2));
                    n_op    = OP_TERM;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = ST_MUL;
                unique case (r_op)
                    OP_TERM: begin
                        n_a  = bracket;
                        n_op = OP_S1;
                    end
                    OP_S1: begin
                        n_s1 = acc_sat;
                        n_a  = next_diff[AW-1:0];
                        n_op = OP_S2;
                    end
                    OP_S2: begin
                        n_s2 = acc_sat;
                        n_a  = next_diff[AW-1:0];
                        n_op = OP_S3;
                    end
                    OP_S3: begin
                        n_s3 = acc_sat;
                        n_a  = next_diff[AW-1:0];
                        n_op = OP_S4;
                    end
                    OP_S4: begin
                        n_s4    = acc_sat;
                        n_state = ST_DONE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_DONE: begin
                if (load_out) begin
                    n_lp        = r_s4;
                    n_bp        = sat_s(ext_s(r_s1) - ext_s(r_s4));
                    n_hp        = sat_s(ext_s(r_x) - ext_s(r_s4));
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_TERM;
            r_out_valid <= 1'b0;
            r_s1        <= '0;
            r_s2        <= '0;
            r_s3        <= '0;
            r_s4        <= '0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
            r_s1        <= n_s1;
            r_s2        <= n_s2;
            r_s3        <= n_s3;
            r_s4        <= n_s4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x  <= n_x;
        r_cv <= n_cv;
        r_c  <= n_c;
        r_fb <= n_fb;
        r_a  <= n_a;
        r_lp <= n_lp;
        r_bp <= n_bp;
        r_hp <= n_hp;
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.lowpass_out  = r_lp;
    assign o_out.bandpass_out = r_bp;
    assign o_out.highpass_out = r_hp;

`ifndef NO_ASSERTIONS
    a_cutoff_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_c >= C_LO_C && r_c <= C_HI_C))
        else $error("cutoff coefficient outside its clamp range");

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (div_quot[NW-1:BW] == '0))
        else $error("gain quotient overflows the feedback gain width");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished while the sequencer was not waiting");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ST_COEF))
        else $error("accepted sample did not start the coefficient step");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result register loaded outside the final step");
`endif

endmodule

`default_nettype wire
